// File: sv/fpt_pkg.sv
// Shared constants for the Frobenius probable-prime tester.
package fpt_pkg;
    localparam int WIDTH   = 32;
    localparam int C_LIMIT = 255;
    // Width of the trial parameter c, wide enough for C_LIMIT plus one step.
    localparam int CW      = $clog2(C_LIMIT + 3);
    // Dividend width of the remainder engine.
    localparam int RW      = (WIDTH > CW) ? WIDTH : CW;
    localparam int SQB     = (WIDTH + 1) / 2;
    localparam int CNTW    = $clog2(RW);
endpackage

// File: sv/frobenius_primality_test.sv
// Quadratic Frobenius probable-prime tester built around bit-serial remainder and multiply engines.
// Small, even, multiple-of-three and square candidates are settled before the c search; each c
// tried runs the Jacobi symbol through repeated bit-serial remainders. A full test runs one round
// per candidate bit of up to nine modular multiplies.
// Throughput: one word at a time; the bit-serial multiply and remainder engines set the rate.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and drops o_valid.
module frobenius_primality_test
    import fpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_candidate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_probable_prime
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_PRE    = 12'b000000000010,
        ST_REM    = 12'b000000000100,
        ST_SQRT   = 12'b000000001000,
        ST_SQCHK  = 12'b000000010000,
        ST_JSTART = 12'b000000100000,
        ST_JLOOP  = 12'b000001000000,
        ST_JEND   = 12'b000010000000,
        ST_MSTART = 12'b000100000000,
        ST_MUL    = 12'b001000000000,
        ST_WB     = 12'b010000000000,
        ST_DONE   = 12'b100000000000
    } t_state;

    typedef enum logic [1:0] {
        TG_N24  = 2'd0,
        TG_JAC  = 2'd1,
        TG_CRES = 2'd2
    } t_tag;

    // Micro-steps of one square-and-multiply round.
    localparam logic [3:0] MS_A1A2 = 4'd0;
    localparam logic [3:0] MS_B1B2 = 4'd1;
    localparam logic [3:0] MS_MULC = 4'd2;
    localparam logic [3:0] MS_A1B2 = 4'd3;
    localparam logic [3:0] MS_A2B1 = 4'd4;
    localparam logic [3:0] MS_A2SQ = 4'd5;
    localparam logic [3:0] MS_B2SQ = 4'd6;
    localparam logic [3:0] MS_SQC  = 4'd7;
    localparam logic [3:0] MS_DBL  = 4'd8;

    t_state            r_state, n_state;
    t_tag              r_tag, n_tag;
    logic [WIDTH-1:0]  r_n, n_n;
    logic [RW-1:0]     r_rv, n_rv;
    logic [WIDTH-1:0]  r_rd, n_rd;
    logic [WIDTH-1:0]  r_rr, n_rr;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [4:0]        r_r24, n_r24;
    logic [SQB-1:0]    r_root, n_root;
    logic [CW-1:0]     r_c, n_c;
    logic [WIDTH-1:0]  r_jx, n_jx;
    logic [WIDTH-1:0]  r_jn, n_jn;
    logic              r_sneg, n_sneg;
    logic              r_small, n_small;
    logic [WIDTH-1:0]  r_cres, n_cres;
    logic [WIDTH-1:0]  r_a1, n_a1, r_b1, n_b1, r_a2, n_a2, r_b2, n_b2;
    logic [WIDTH-1:0]  r_ta, n_ta, r_tb, n_tb;
    logic [WIDTH-1:0]  r_e, n_e;
    logic [3:0]        r_step, n_step;
    logic [WIDTH-1:0]  r_mx, n_mx, r_my, n_my, r_acc, n_acc;
    logic              r_valid, n_valid;
    logic              r_res, n_res;
    logic              r_pass, n_pass;

    logic [WIDTH:0]    rem2, rem3;
    logic [WIDTH-1:0]  rem_val;
    logic [WIDTH:0]    m2, m2r, m3;
    logic [WIDTH-1:0]  mul_val;
    logic [SQB-1:0]    trial;
    logic [2*SQB-1:0]  trial_sq, root_sq, n_wide;
    logic [WIDTH:0]    dbl_sum;
    logic [WIDTH-1:0]  a2_dbl;
    logic [WIDTH-1:0]  op_x, op_y, dest_val;
    logic              op_acc, op_dest_a;
    logic [WIDTH:0]    wb_sum;
    logic [WIDTH-1:0]  wb_val;
    logic [WIDTH-1:0]  a_val;

    function automatic logic [1:0] mod3(input logic [4:0] v);
        logic [4:0] t;
        t = v;
        if (t >= 5'd12) t = t - 5'd12;
        if (t >= 5'd6)  t = t - 5'd6;
        if (t >= 5'd3)  t = t - 5'd3;
        return t[1:0];
    endfunction

    assign o_stall             = (r_state != ST_IDLE);
    assign o_valid             = r_valid;
    assign o_is_probable_prime = r_res;

    always_comb begin
        // Remainder engine: one restoring step per cycle.
        rem2    = {r_rr, r_rv[RW-1]};
        rem3    = (rem2 >= {1'b0, r_rd}) ? rem2 - {1'b0, r_rd} : rem2;
        rem_val = rem3[WIDTH-1:0];

        // Modular multiply engine: double, then add the next multiplier bit.
        m2      = {r_acc, 1'b0};
        m2r     = (m2 >= {1'b0, r_n}) ? m2 - {1'b0, r_n} : m2;
        m3      = m2r + (r_my[WIDTH-1] ? {1'b0, r_mx} : '0);
        m3      = (m3 >= {1'b0, r_n}) ? m3 - {1'b0, r_n} : m3;
        mul_val = m3[WIDTH-1:0];

        trial    = r_root | (SQB'(1) << r_cnt);
        trial_sq = (2*SQB)'(trial) * (2*SQB)'(trial);
        root_sq  = (2*SQB)'(r_root) * (2*SQB)'(r_root);
        n_wide   = (2*SQB)'(r_n);

        dbl_sum = {r_a2, 1'b0};
        dbl_sum = (dbl_sum >= {1'b0, r_n}) ? dbl_sum - {1'b0, r_n} : dbl_sum;
        a2_dbl  = dbl_sum[WIDTH-1:0];

        a_val = r_small ? WIDTH'(2) : WIDTH'(1);

        case (r_step)
            MS_A1A2: begin op_x = r_a1;   op_y = r_a2;   op_acc = 1'b0; op_dest_a = 1'b1; end
            MS_B1B2: begin op_x = r_b1;   op_y = r_b2;   op_acc = 1'b0; op_dest_a = 1'b0; end
            MS_MULC: begin op_x = r_tb;   op_y = r_cres; op_acc = 1'b1; op_dest_a = 1'b1; end
            MS_A1B2: begin op_x = r_a1;   op_y = r_b2;   op_acc = 1'b0; op_dest_a = 1'b0; end
            MS_A2B1: begin op_x = r_a2;   op_y = r_b1;   op_acc = 1'b1; op_dest_a = 1'b0; end
            MS_A2SQ: begin op_x = r_a2;   op_y = r_a2;   op_acc = 1'b0; op_dest_a = 1'b1; end
            MS_B2SQ: begin op_x = r_b2;   op_y = r_b2;   op_acc = 1'b0; op_dest_a = 1'b0; end
            MS_SQC:  begin op_x = r_tb;   op_y = r_cres; op_acc = 1'b1; op_dest_a = 1'b1; end
            MS_DBL:  begin op_x = a2_dbl; op_y = r_b2;   op_acc = 1'b0; op_dest_a = 1'b0; end
            default: begin op_x = '0;     op_y = '0;     op_acc = 1'b0; op_dest_a = 1'b0; end
        endcase

        dest_val = op_dest_a ? r_ta : r_tb;
        wb_sum   = {1'b0, dest_val} + {1'b0, r_acc};
        wb_sum   = (wb_sum >= {1'b0, r_n}) ? wb_sum - {1'b0, r_n} : wb_sum;
        wb_val   = op_acc ? wb_sum[WIDTH-1:0] : r_acc;
    end

    always_comb begin
        n_state = r_state;
        n_tag   = r_tag;
        n_n     = r_n;
        n_rv    = r_rv;
        n_rd    = r_rd;
        n_rr    = r_rr;
        n_cnt   = r_cnt;
        n_r24   = r_r24;
        n_root  = r_root;
        n_c     = r_c;
        n_jx    = r_jx;
        n_jn    = r_jn;
        n_sneg  = r_sneg;
        n_small = r_small;
        n_cres  = r_cres;
        n_a1    = r_a1;
        n_b1    = r_b1;
        n_a2    = r_a2;
        n_b2    = r_b2;
        n_ta    = r_ta;
        n_tb    = r_tb;
        n_e     = r_e;
        n_step  = r_step;
        n_mx    = r_mx;
        n_my    = r_my;
        n_acc   = r_acc;
        n_res   = r_res;
        n_pass  = r_pass;
        n_valid = r_valid;

        if (r_valid && !i_stall) n_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_n     = i_candidate[WIDTH-1:0];
                    n_state = ST_PRE;
                end
            end
            ST_PRE: begin
                if (r_n < WIDTH'(2)) begin
                    n_pass  = 1'b0;
                    n_state = ST_DONE;
                end else if (r_n == WIDTH'(2) || r_n == WIDTH'(3)) begin
                    n_pass  = 1'b1;
                    n_state = ST_DONE;
                end else if (!r_n[0]) begin
                    n_pass  = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_rv    = RW'(r_n);
                    n_rd    = WIDTH'(24);
                    n_rr    = '0;
                    n_cnt   = CNTW'(RW - 1);
                    n_tag   = TG_N24;
                    n_state = ST_REM;
                end
            end
            ST_REM: begin
                n_rr  = rem_val;
                n_rv  = {r_rv[RW-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    case (r_tag)
                        TG_N24: begin
                            n_r24 = rem_val[4:0];
                            if (mod3(rem_val[4:0]) == 2'd0) begin
                                n_pass  = 1'b0;
                                n_state = ST_DONE;
                            end else begin
                                n_root  = '0;
                                n_cnt   = CNTW'(SQB - 1);
                                n_state = ST_SQRT;
                            end
                        end
                        TG_JAC: begin
                            n_jx    = rem_val;
                            n_state = ST_JLOOP;
                        end
                        TG_CRES: begin
                            n_cres  = rem_val;
                            n_small = 1'b0;
                            n_a1    = WIDTH'(1);
                            n_b1    = '0;
                            n_a2    = WIDTH'(1);
                            n_b2    = WIDTH'(1);
                            n_e     = r_n;
                            n_step  = r_n[0] ? MS_A1A2 : MS_A2SQ;
                            n_state = ST_MSTART;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SQRT: begin
                if (trial_sq <= n_wide) n_root = trial;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = ST_SQCHK;
            end
            ST_SQCHK: begin
                if (root_sq == n_wide) begin
                    n_pass  = 1'b0;
                    n_state = ST_DONE;
                end else if (r_n[1:0] == 2'd3 || r_n[2:0] == 3'd5 || r_r24 == 5'd17) begin
                    if (r_n[1:0] == 2'd3) begin
                        n_cres  = r_n - 1'b1;
                        n_small = 1'b1;
                    end else if (r_n[2:0] == 3'd5) begin
                        n_cres  = WIDTH'(2);
                        n_small = 1'b1;
                    end else begin
                        n_cres  = WIDTH'(3);
                        n_small = 1'b0;
                    end
                    n_a1    = WIDTH'(1);
                    n_b1    = '0;
                    n_a2    = (r_n[1:0] == 2'd3 || r_n[2:0] == 3'd5) ? WIDTH'(2) : WIDTH'(1);
                    n_b2    = WIDTH'(1);
                    n_e     = r_n;
                    n_step  = r_n[0] ? MS_A1A2 : MS_A2SQ;
                    n_state = ST_MSTART;
                end else begin
                    n_c     = CW'(5);
                    n_state = ST_JSTART;
                end
            end
            ST_JSTART: begin
                if (r_c > CW'(C_LIMIT)) begin
                    n_pass  = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_sneg  = 1'b0;
                    n_jn    = r_n;
                    n_rv    = RW'(r_c);
                    n_rd    = r_n;
                    n_rr    = '0;
                    n_cnt   = CNTW'(RW - 1);
                    n_tag   = TG_JAC;
                    n_state = ST_REM;
                end
            end
            ST_JLOOP: begin
                if (r_jx == '0) begin
                    n_state = ST_JEND;
                end else if (!r_jx[0]) begin
                    n_jx = {1'b0, r_jx[WIDTH-1:1]};
                    if (r_jn[2:0] == 3'd3 || r_jn[2:0] == 3'd5) n_sneg = !r_sneg;
                end else begin
                    // Reciprocity: swap the pair, then reduce the new top by the new bottom.
                    if (r_jx[1:0] == 2'd3 && r_jn[1:0] == 2'd3) n_sneg = !r_sneg;
                    n_jn    = r_jx;
                    n_rv    = RW'(r_jn);
                    n_rd    = r_jx;
                    n_rr    = '0;
                    n_cnt   = CNTW'(RW - 1);
                    n_tag   = TG_JAC;
                    n_state = ST_REM;
                end
            end
            ST_JEND: begin
                if (r_jn != WIDTH'(1)) begin
                    n_pass  = 1'b0;
                    n_state = ST_DONE;
                end else if (r_sneg) begin
                    n_rv    = RW'(r_c);
                    n_rd    = r_n;
                    n_rr    = '0;
                    n_cnt   = CNTW'(RW - 1);
                    n_tag   = TG_CRES;
                    n_state = ST_REM;
                end else begin
                    n_c     = r_c + CW'(2);
                    n_state = ST_JSTART;
                end
            end
            ST_MSTART: begin
                n_mx    = op_x;
                n_my    = op_y;
                n_acc   = '0;
                n_cnt   = CNTW'(WIDTH - 1);
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_acc = mul_val;
                n_my  = {r_my[WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = ST_WB;
            end
            ST_WB: begin
                if (op_dest_a) n_ta = wb_val;
                else           n_tb = wb_val;
                n_state = ST_MSTART;
                if (r_step == MS_A2B1) begin
                    n_a1   = r_ta;
                    n_b1   = wb_val;
                    n_step = MS_A2SQ;
                end else if (r_step == MS_DBL) begin
                    n_a2 = r_ta;
                    n_b2 = wb_val;
                    n_e  = {1'b0, r_e[WIDTH-1:1]};
                    if (r_e[WIDTH-1:1] == '0) begin
                        n_pass  = (r_a1 == a_val) && (r_b1 == r_n - 1'b1);
                        n_state = ST_DONE;
                    end else begin
                        n_step = r_e[1] ? MS_A1A2 : MS_A2SQ;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DONE: begin
                // The verdict moves to the output only once the previous word has left.
                if (!r_valid || !i_stall) begin
                    n_res   = r_pass;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_n     <= n_n;
        r_rv    <= n_rv;
        r_rd    <= n_rd;
        r_rr    <= n_rr;
        r_cnt   <= n_cnt;
        r_r24   <= n_r24;
        r_root  <= n_root;
        r_c     <= n_c;
        r_jx    <= n_jx;
        r_jn    <= n_jn;
        r_sneg  <= n_sneg;
        r_small <= n_small;
        r_cres  <= n_cres;
        r_a1    <= n_a1;
        r_b1    <= n_b1;
        r_a2    <= n_a2;
        r_b2    <= n_b2;
        r_ta    <= n_ta;
        r_tb    <= n_tb;
        r_e     <= n_e;
        r_step  <= n_step;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_pass  <= n_pass;
    end

endmodule

// File: tb/sv/tb_frobenius_primality_test.sv
// Testbench for the Frobenius probable-prime tester: directed table plus random candidates.
`timescale 1ns / 1ps

module tb_frobenius_primality_test;
    import fpt_pkg::*;

    localparam int DIRECTED_COUNT = 22;
    localparam int RANDOM_COUNT   = 300;
    localparam longint CYCLE_LIMIT = 64'd150_000_000;
    localparam int DRAIN_CYCLES   = 20000;

    // Marks a table row whose answer comes from the predictor.
    localparam logic [1:0] ANS_PREDICT = 2'd2;

    typedef struct packed {
        logic [31:0] candidate;
        logic [1:0]  answer;
    } t_probe_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_candidate;
    logic        o_valid;
    logic        i_stall;
    logic        o_is_probable_prime;

    bit          verdict_q[$];
    int          error_count;
    longint      cycle_count;
    bit          rx_quiet;
    t_probe_row  probe_table[DIRECTED_COUNT];

    frobenius_primality_test dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_candidate         (i_candidate),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_is_probable_prime (o_is_probable_prime)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y,
                                                longint unsigned n);
        return (x * y) % n;
    endfunction

    function automatic bit perfect_square_check(longint unsigned n);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo * lo == n;
    endfunction

    function automatic int jacobi_symbol(longint unsigned x, longint unsigned n);
        int s;
        longint unsigned t;
        s = 1;
        x = x % n;
        while (x != 0) begin
            while (x[0] == 1'b0) begin
                x = x >> 1;
                if ((n & 7) == 3 || (n & 7) == 5) s = -s;
            end
            t = x;
            x = n;
            n = t;
            if ((x & 3) == 3 && (n & 3) == 3) s = -s;
            x = x % n;
        end
        return (n == 1) ? s : 0;
    endfunction

    function automatic bit frobenius_verdict(logic [31:0] raw);
        longint unsigned n, cres, a, a1, b1, a2, b2, e, na, nb, c;
        bit narrow_c;
        int j;
        n = raw & ((64'd1 << WIDTH) - 1);
        if (n < 2) return 1'b0;
        if (n == 2 || n == 3) return 1'b1;
        if (n % 2 == 0 || n % 3 == 0) return 1'b0;
        if (perfect_square_check(n)) return 1'b0;
        if (n % 4 == 3) begin
            cres = n - 1;
            narrow_c = 1'b1;
        end else if (n % 8 == 5) begin
            cres = 2 % n;
            narrow_c = 1'b1;
        end else if (n % 24 == 17) begin
            cres = 3 % n;
            narrow_c = 1'b0;
        end else begin
            c = 5;
            forever begin
                if (c > C_LIMIT) return 1'b0;
                j = jacobi_symbol(c, n);
                if (j == 0) return 1'b0;
                if (j == -1) break;
                c += 2;
            end
            cres = c % n;
            narrow_c = 1'b0;
        end
        a = narrow_c ? 2 : 1;
        a1 = 1;
        b1 = 0;
        a2 = a;
        b2 = 1;
        e = n;
        while (e > 0) begin
            if (e[0]) begin
                na = (mod_mul(a1, a2, n) + mod_mul(mod_mul(b1, b2, n), cres, n)) % n;
                nb = (mod_mul(a1, b2, n) + mod_mul(a2, b1, n)) % n;
                a1 = na;
                b1 = nb;
            end
            na = (mod_mul(a2, a2, n) + mod_mul(mod_mul(b2, b2, n), cres, n)) % n;
            nb = mod_mul((2 * a2) % n, b2, n);
            a2 = na;
            b2 = nb;
            e = e >> 1;
        end
        return a1 == a && b1 == n - 1;
    endfunction

    // Fills the directed table; known answers only where they are obvious.
    initial begin
        probe_table[0]  = '{32'd0, 2'd0};
        probe_table[1]  = '{32'd1, 2'd0};
        probe_table[2]  = '{32'd2, 2'd1};
        probe_table[3]  = '{32'd3, 2'd1};
        probe_table[4]  = '{32'd4, 2'd0};
        probe_table[5]  = '{32'd9, 2'd0};
        probe_table[6]  = '{32'd25, 2'd0};
        probe_table[7]  = '{32'd7, ANS_PREDICT};
        probe_table[8]  = '{32'd13, ANS_PREDICT};
        probe_table[9]  = '{32'd17, ANS_PREDICT};
        probe_table[10] = '{32'd73, ANS_PREDICT};
        probe_table[11] = '{32'd97, ANS_PREDICT};
        probe_table[12] = '{32'd145, ANS_PREDICT};   // Jacobi zero during the c search
        probe_table[13] = '{32'd35, ANS_PREDICT};
        probe_table[14] = '{32'd1369, 2'd0};
        probe_table[15] = '{32'hFFFF_FFFF, 2'd0};
        probe_table[16] = '{32'hFFFF_FFFB, ANS_PREDICT};
        probe_table[17] = '{32'hFFFE_0001, 2'd0};
        probe_table[18] = '{32'h8000_0000, 2'd0};
        probe_table[19] = '{32'h7FFF_FFFF, ANS_PREDICT};
        probe_table[20] = '{32'd561, ANS_PREDICT};
        probe_table[21] = '{32'd1_000_000_009, ANS_PREDICT};
    end

    task automatic send_word(logic [31:0] value, logic [1:0] answer, bit may_idle);
        while (may_idle && $urandom_range(99) < 35) @(negedge i_clk);
        i_valid     <= 1'b1;
        i_candidate <= value;
        if (answer == ANS_PREDICT) verdict_q.push_back(frobenius_verdict(value));
        else verdict_q.push_back(answer[0]);
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid <= 1'b0;
        // The block is busy after a word, so nothing is lost here.
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_candidate();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = $urandom();
            1, 2: v = $urandom_range(5000);
            3: v = $urandom_range(65535) * 24 + 1;  // hits the c search
            4: v = $urandom() | 32'h8000_0001;
            default: v = $urandom() | 32'd1;
        endcase
        return v;
    endfunction

    // Receiver stall: random, except for a quiet stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= rx_quiet ? 1'b0 : ($urandom_range(99) < 35);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $error("is_probable_prime: unexpected word, actual %0b",
                       o_is_probable_prime);
                error_count++;
            end else begin
                if (o_is_probable_prime !== verdict_q[0]) begin
                    $error("is_probable_prime: expected %0b actual %0b",
                           verdict_q[0], o_is_probable_prime);
                    error_count++;
                end
                void'(verdict_q.pop_front());
            end
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_frobenius_primality_test: done, errors");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        rx_quiet    = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_candidate = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIRECTED_COUNT; k++)
            send_word(probe_table[k].candidate, probe_table[k].answer, 1'b1);

        // Let the pipeline drain fully before the random part.
        while (verdict_q.size() != 0) @(negedge i_clk);

        for (int k = 0; k < RANDOM_COUNT; k++) begin
            rx_quiet = (k >= 100 && k < 140);
            send_word(random_candidate(), ANS_PREDICT, !rx_quiet);
        end
        rx_quiet = 1'b0;

        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("tb_frobenius_primality_test: done, clean");
        else
            $display("tb_frobenius_primality_test: done, errors");
        $finish;
    end
endmodule
